>>> hdl/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg
// Types, codes and fixed field widths shared by the hopscotch hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package hht_pkg;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 31;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int MOD_W    = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    value_out;
	} out_item_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_MOD, S_HOME,
		S_SC_RD, S_SC_CHK, S_PR_RD, S_PR_CHK,
		S_DIST, S_MV_RD, S_MV_CHK, S_MV_KRD, S_MV_WR1, S_MV_WR2,
		S_FIN_RD, S_FIN_WR,
		S_RM_MRD, S_RM_MLD, S_RM_RD, S_RM_CHK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic                load_item;
		logic                mod_step;
		logic                home_ld;
		logic                pos_home;
		logic                pos_inc;
		logic                clr_wr;
		logic                key_sel_src;
		logic                map_sel_base;
		logic                bits_ld;
		logic                rm_hit;
		logic                hole_ld;
		logic                dist_ld;
		logic                mv_chk;
		logic                mv_wr1;
		logic                mv_wr2;
		logic                fin_wr;
		logic                code_ld;
		logic [STATUS_W-1:0] code;
		logic                res_load;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              key_zero;
		logic              mod_last;
		logic              clr_last;
		logic              scan_last;
		logic              probe_last;
		logic              key_hit;
		logic              key_empty;
		logic              bit_hit;
		logic              dist_far;
		logic              mv_found;
		logic              span_last;
	} stat_t;

endpackage

`default_nettype wire

>>> hdl/hopscotch_hash_table.sv
// ----------------------------------------------------------------------------
// hopscotch_hash_table
// Hopscotch hash table: insert, lookup and remove of key/value pairs.
// ----------------------------------------------------------------------------
// Sequence: a reciprocal-multiply key remainder and a home step, then a read and a check per
// bucket visited through the shared key/value read port; a lookup miss scans the whole
// neighbourhood, an insert also probes for an empty bucket and moves the hole toward home.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: a clearing pass over every bucket zeroes keys and bitmaps; no input is taken.
`default_nettype none

module hopscotch_hash_table #(
	parameter int TABLE_SIZE  = 1024,
	parameter int NBHD_SIZE   = 32,
	parameter int PROBE_LIMIT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire hht_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output hht_pkg::out_item_t      out_data
);

	hht_pkg::cmd_t  cmd;
	hht_pkg::stat_t stat;

	hht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hht_dp #(
		.TABLE_SIZE  (TABLE_SIZE),
		.NBHD_SIZE   (NBHD_SIZE),
		.PROBE_LIMIT (PROBE_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

>>> hdl/hht_ram.sv
// ----------------------------------------------------------------------------
// hht_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/hht_ctrl.sv
// ----------------------------------------------------------------------------
// hht_ctrl
// Sequencer for clear, hashing, scan, probe, displacement and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire hht_pkg::stat_t stat,
	output hht_pkg::cmd_t       cmd
);

	hht_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hht_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == hht_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hht_pkg::S_CLEAR: if (stat.clr_last) state_d = hht_pkg::S_IDLE;
			hht_pkg::S_IDLE:  if (in_valid) state_d = hht_pkg::S_MOD;
			hht_pkg::S_MOD:   if (stat.mod_last) state_d = hht_pkg::S_HOME;
			hht_pkg::S_HOME: begin
				if (stat.key_zero) begin
					state_d = hht_pkg::S_RESP;
				end else if (stat.kind == hht_pkg::KIND_INSERT ||
						stat.kind == hht_pkg::KIND_LOOKUP) begin
					state_d = hht_pkg::S_SC_RD;
				end else if (stat.kind == hht_pkg::KIND_REMOVE) begin
					state_d = hht_pkg::S_RM_MRD;
				end else begin
					state_d = hht_pkg::S_RESP;
				end
			end
			hht_pkg::S_SC_RD: state_d = hht_pkg::S_SC_CHK;
			hht_pkg::S_SC_CHK: begin
				if (stat.key_hit) begin
					state_d = hht_pkg::S_RESP;
				end else if (stat.scan_last) begin
					state_d = (stat.kind == hht_pkg::KIND_LOOKUP) ?
						hht_pkg::S_RESP : hht_pkg::S_PR_RD;
				end else begin
					state_d = hht_pkg::S_SC_RD;
				end
			end
			hht_pkg::S_PR_RD: state_d = hht_pkg::S_PR_CHK;
			hht_pkg::S_PR_CHK: begin
				if (stat.key_empty) begin
					state_d = hht_pkg::S_DIST;
				end else if (stat.probe_last) begin
					state_d = hht_pkg::S_RESP;
				end else begin
					state_d = hht_pkg::S_PR_RD;
				end
			end
			hht_pkg::S_DIST: state_d = stat.dist_far ? hht_pkg::S_MV_RD : hht_pkg::S_FIN_RD;
			hht_pkg::S_MV_RD: state_d = hht_pkg::S_MV_CHK;
			hht_pkg::S_MV_CHK: begin
				if (stat.mv_found) begin
					state_d = hht_pkg::S_MV_KRD;
				end else if (stat.span_last) begin
					state_d = hht_pkg::S_RESP;
				end else begin
					state_d = hht_pkg::S_MV_RD;
				end
			end
			hht_pkg::S_MV_KRD: state_d = hht_pkg::S_MV_WR1;
			hht_pkg::S_MV_WR1: state_d = hht_pkg::S_MV_WR2;
			hht_pkg::S_MV_WR2: state_d = hht_pkg::S_DIST;
			hht_pkg::S_FIN_RD: state_d = hht_pkg::S_FIN_WR;
			hht_pkg::S_FIN_WR: state_d = hht_pkg::S_RESP;
			hht_pkg::S_RM_MRD: state_d = hht_pkg::S_RM_MLD;
			hht_pkg::S_RM_MLD: state_d = hht_pkg::S_RM_RD;
			hht_pkg::S_RM_RD:  state_d = hht_pkg::S_RM_CHK;
			hht_pkg::S_RM_CHK: begin
				if ((stat.bit_hit && stat.key_hit) || stat.scan_last) begin
					state_d = hht_pkg::S_RESP;
				end else begin
					state_d = hht_pkg::S_RM_RD;
				end
			end
			hht_pkg::S_RESP: if (!out_valid_q || out_ready) state_d = hht_pkg::S_IDLE;
			default: state_d = hht_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			hht_pkg::S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.pos_inc = 1'b1;
			end
			hht_pkg::S_IDLE: cmd.load_item = in_valid;
			hht_pkg::S_MOD:  cmd.mod_step = 1'b1;
			hht_pkg::S_HOME: begin
				cmd.home_ld = 1'b1;
				cmd.code_ld = 1'b1;
				cmd.code    = hht_pkg::ST_ABSENT;
			end
			hht_pkg::S_SC_RD: ;
			hht_pkg::S_SC_CHK: begin
				if (stat.key_hit) begin
					cmd.code_ld = 1'b1;
					cmd.code    = (stat.kind == hht_pkg::KIND_LOOKUP) ?
						hht_pkg::ST_OK : hht_pkg::ST_DUP;
				end else if (stat.scan_last) begin
					cmd.pos_home = 1'b1;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			hht_pkg::S_PR_RD: ;
			hht_pkg::S_PR_CHK: begin
				if (stat.key_empty) begin
					cmd.hole_ld = 1'b1;
				end else if (stat.probe_last) begin
					cmd.code_ld = 1'b1;
					cmd.code    = hht_pkg::ST_FULL;
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			hht_pkg::S_DIST: cmd.dist_ld = 1'b1;
			hht_pkg::S_MV_RD: cmd.map_sel_base = 1'b1;
			hht_pkg::S_MV_CHK: begin
				cmd.map_sel_base = 1'b1;
				cmd.mv_chk       = 1'b1;
				if (!stat.mv_found && stat.span_last) begin
					cmd.code_ld = 1'b1;
					cmd.code    = hht_pkg::ST_FULL;
				end
			end
			hht_pkg::S_MV_KRD: cmd.key_sel_src = 1'b1;
			hht_pkg::S_MV_WR1: begin
				cmd.key_sel_src = 1'b1;
				cmd.mv_wr1      = 1'b1;
			end
			hht_pkg::S_MV_WR2: cmd.mv_wr2 = 1'b1;
			hht_pkg::S_FIN_RD: ;
			hht_pkg::S_FIN_WR: begin
				cmd.fin_wr  = 1'b1;
				cmd.code_ld = 1'b1;
				cmd.code    = hht_pkg::ST_OK;
			end
			hht_pkg::S_RM_MRD: ;
			hht_pkg::S_RM_MLD: cmd.bits_ld = 1'b1;
			hht_pkg::S_RM_RD:  ;
			hht_pkg::S_RM_CHK: begin
				if (stat.bit_hit && stat.key_hit) begin
					cmd.rm_hit  = 1'b1;
					cmd.code_ld = 1'b1;
					cmd.code    = hht_pkg::ST_OK;
				end else if (!stat.scan_last) begin
					cmd.pos_inc = 1'b1;
				end
			end
			hht_pkg::S_RESP: cmd.res_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hht_pkg::S_CLEAR) |-> !in_ready)
		else $error("item taken during clearing pass");

	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == hht_pkg::S_MOD))
		else $error("accepted item did not start hashing");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> (state_q == hht_pkg::S_IDLE))
		else $error("result loaded without return to idle");

endmodule

`default_nettype wire

>>> hdl/hht_dp.sv
// ----------------------------------------------------------------------------
// hht_dp
// Bucket stores, hashing remainder unit, scan pointers and displacement math.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_dp #(
	parameter int TABLE_SIZE  = 1024,
	parameter int NBHD_SIZE   = 32,
	parameter int PROBE_LIMIT = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hht_pkg::in_item_t   in_data,
	input  wire hht_pkg::cmd_t       cmd,
	output hht_pkg::stat_t           stat,
	output hht_pkg::out_item_t       out_data
);

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int HOP_W   = $clog2(NBHD_SIZE);
	localparam int CNT_TOP = (PROBE_LIMIT > NBHD_SIZE) ? PROBE_LIMIT : NBHD_SIZE;
	localparam int CNT_W   = $clog2(CNT_TOP);
	localparam int SUM_W   = IDX_W + 7;
	localparam int HM1     = (NBHD_SIZE - 1) % TABLE_SIZE;
	localparam int SH      = hht_pkg::KEY_W + IDX_W;
	localparam int QW      = hht_pkg::KEY_W + 32 - SH;
	localparam int MOD_LAST = 2;

	localparam longint unsigned RECIP_L = (64'd1 << SH) / TABLE_SIZE;
	localparam logic [31:0]               RECIP = 32'(RECIP_L);

	localparam logic [SUM_W-1:0]           TS_S  = SUM_W'(TABLE_SIZE);
	localparam logic [IDX_W:0]             TS_R  = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [hht_pkg::KEY_W-1:0] TS_K  = hht_pkg::KEY_W'(TABLE_SIZE);
	localparam logic [IDX_W-1:0]           LAST  = IDX_W'(TABLE_SIZE - 1);

	logic [hht_pkg::KIND_W-1:0]   kind_q;
	logic [hht_pkg::KEY_W-1:0]    key_q, qts_q;
	logic [hht_pkg::KEY_W+31:0]   prod_q;
	logic [hht_pkg::VAL_W-1:0]    val_q, vout_q;
	logic [IDX_W-1:0]             rem_q, home_q, pos_q, hole_q, dist_q, base_q, src_q;
	logic [hht_pkg::MOD_W-1:0]    mcnt_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [HOP_W-1:0]             span_q;
	logic [NBHD_SIZE-1:0]         bits_q;
	logic [hht_pkg::STATUS_W-1:0] code_q;
	hht_pkg::out_item_t           res_q;

	logic [hht_pkg::KEY_W-1:0] key_rd, key_wd;
	logic [hht_pkg::VAL_W-1:0] val_rd, val_wd;
	logic [NBHD_SIZE-1:0]      map_rd, map_wd;
	logic [IDX_W-1:0]          key_ra, key_wa, val_wa, map_ra, map_wa;
	logic                      key_we, val_we, map_we;

	logic [QW-1:0]             quo;
	logic [QW+IDX_W:0]         qts_full;
	logic [hht_pkg::KEY_W-1:0] diff, rem_fix;
	logic [SUM_W-1:0]     dist_s, base_s, src_s;
	logic [IDX_W-1:0]     dist_c, base_c, src_c, pos_nx, base_nx;
	logic [NBHD_SIZE-1:0] span_mask, masked, map_new;
	logic [HOP_W-1:0]     lsb;
	logic                 found;

	assign quo      = prod_q[hht_pkg::KEY_W+31:SH];
	assign qts_full = quo * TS_R;
	assign diff     = key_q - qts_q;
	assign rem_fix  = (diff >= TS_K) ? (diff - TS_K) : diff;

	assign pos_nx  = (pos_q == LAST) ? '0 : pos_q + 1'b1;
	assign base_nx = (base_q == LAST) ? '0 : base_q + 1'b1;

	always_comb begin
		dist_s = SUM_W'(hole_q) + TS_S - SUM_W'(home_q);
		if (dist_s >= TS_S) dist_s = dist_s - TS_S;
		dist_c = dist_s[IDX_W-1:0];

		base_s = SUM_W'(hole_q) + TS_S - SUM_W'(HM1);
		if (base_s >= TS_S) base_s = base_s - TS_S;
		base_c = base_s[IDX_W-1:0];

		span_mask = (NBHD_SIZE'(1) << span_q) - NBHD_SIZE'(1);
		masked    = map_rd & span_mask;
		found     = |masked;
		lsb       = '0;
		for (int i = NBHD_SIZE - 1; i >= 0; i--) begin
			if (masked[i]) lsb = HOP_W'(i);
		end
		map_new = (map_rd | (NBHD_SIZE'(1) << span_q)) & ~(NBHD_SIZE'(1) << lsb);

		src_s = SUM_W'(base_q) + SUM_W'(lsb);
		if (src_s >= TS_S) src_s = src_s - TS_S;
		if (src_s >= TS_S) src_s = src_s - TS_S;
		src_c = src_s[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.pos_home || cmd.home_ld) begin
			pos_q <= cmd.home_ld ? rem_q : home_q;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= in_data.kind;
			key_q   <= in_data.key;
			val_q   <= in_data.value;
			vout_q  <= '0;
			mcnt_q  <= '0;
		end
		if (cmd.mod_step) begin
			prod_q <= key_q * RECIP;
			qts_q  <= qts_full[hht_pkg::KEY_W-1:0];
			rem_q  <= rem_fix[IDX_W-1:0];
			mcnt_q <= mcnt_q + 1'b1;
		end
		if (cmd.home_ld) begin
			home_q <= rem_q;
		end
		if (cmd.home_ld || cmd.pos_home) begin
			cnt_q <= '0;
		end else if (cmd.pos_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.hole_ld) begin
			hole_q <= pos_q;
		end
		if (cmd.dist_ld) begin
			dist_q <= dist_c;
			base_q <= base_c;
			span_q <= HOP_W'(NBHD_SIZE - 1);
		end
		if (cmd.mv_chk) begin
			if (found) begin
				src_q <= src_c;
			end else begin
				span_q <= span_q - 1'b1;
				base_q <= base_nx;
			end
		end
		if (cmd.mv_wr2) begin
			hole_q <= src_q;
		end
		if (cmd.bits_ld) begin
			bits_q <= map_rd;
		end
		if (cmd.rm_hit) begin
			vout_q <= val_rd;
		end
		if (cmd.code_ld) begin
			code_q <= cmd.code;
		end
		if (cmd.res_load) begin
			res_q.status    <= code_q;
			res_q.value_out <= vout_q;
		end
	end

	always_comb begin
		key_ra = cmd.key_sel_src ? src_q : pos_q;
		map_ra = cmd.map_sel_base ? base_q : home_q;

		key_we = 1'b0;
		key_wa = pos_q;
		key_wd = '0;
		priority if (cmd.clr_wr || cmd.rm_hit) begin
			key_we = 1'b1;
		end else if (cmd.mv_wr1) begin
			key_we = 1'b1;
			key_wa = hole_q;
			key_wd = key_rd;
		end else if (cmd.mv_wr2) begin
			key_we = 1'b1;
			key_wa = src_q;
		end else if (cmd.fin_wr) begin
			key_we = 1'b1;
			key_wa = hole_q;
			key_wd = key_q;
		end else begin
			key_we = 1'b0;
		end

		val_we = cmd.mv_wr1 || cmd.fin_wr;
		val_wa = hole_q;
		val_wd = cmd.fin_wr ? val_q : val_rd;

		map_we = 1'b0;
		map_wa = pos_q;
		map_wd = '0;
		priority if (cmd.clr_wr) begin
			map_we = 1'b1;
		end else if (cmd.rm_hit) begin
			map_we = 1'b1;
			map_wa = home_q;
			map_wd = bits_q & ~(NBHD_SIZE'(1) << cnt_q[HOP_W-1:0]);
		end else if (cmd.mv_chk && found) begin
			map_we = 1'b1;
			map_wa = base_q;
			map_wd = map_new;
		end else if (cmd.fin_wr) begin
			map_we = 1'b1;
			map_wa = home_q;
			map_wd = map_rd | (NBHD_SIZE'(1) << dist_q[HOP_W-1:0]);
		end else begin
			map_we = 1'b0;
		end
	end

	hht_ram #(.WIDTH(hht_pkg::KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_wa),
		.wdata (key_wd),
		.raddr (key_ra),
		.rdata (key_rd)
	);

	hht_ram #(.WIDTH(hht_pkg::VAL_W), .DEPTH(TABLE_SIZE)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_wa),
		.wdata (val_wd),
		.raddr (key_ra),
		.rdata (val_rd)
	);

	hht_ram #(.WIDTH(NBHD_SIZE), .DEPTH(TABLE_SIZE)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wa),
		.wdata (map_wd),
		.raddr (map_ra),
		.rdata (map_rd)
	);

	always_comb begin
		stat.kind       = kind_q;
		stat.key_zero   = (key_q == '0);
		stat.mod_last   = (mcnt_q == hht_pkg::MOD_W'(MOD_LAST));
		stat.clr_last   = (pos_q == LAST);
		stat.scan_last  = (cnt_q == CNT_W'(NBHD_SIZE - 1));
		stat.probe_last = (cnt_q == CNT_W'(PROBE_LIMIT - 1));
		stat.key_hit    = (key_rd == key_q);
		stat.key_empty  = (key_rd == '0);
		stat.bit_hit    = bits_q[cnt_q[HOP_W-1:0]];
		stat.dist_far   = (SUM_W'(dist_c) >= SUM_W'(NBHD_SIZE));
		stat.mv_found   = found;
		stat.span_last  = (span_q == HOP_W'(1));
	end

	assign out_data = res_q;

endmodule

`default_nettype wire
